[sv/hsg_pkg.sv]
// shared types and constants of the hand swipe gesture detector
package hsg_pkg;

  // configuration port
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_H_GAP     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_V_GAP     = 2'd2;

  localparam logic [CFG_W-1:0] MIN_SPEED_RST = 16'd256;
  localparam logic [CFG_W-1:0] GAP_RST       = 16'd500;

  // products with a time step wider than this many bits saturate
  localparam int DT_CLAMP_BITS = 40;

  // depth of the queue between classifier and tracker
  localparam int QUEUE_DEPTH = 2;

  // axis order: left x, left y, right x, right y
  localparam int NUM_AXES = 4;

  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_POS  = 2'd1,
    CLS_NEG  = 2'd2
  } cls_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_POS  = 2'd1,
    DIR_NEG  = 2'd2
  } dir_e;

  // classified frame handed from the front to the back
  typedef struct packed {
    logic                  changed;
    logic                  dt_nz;
    cls_e [NUM_AXES-1:0]   cls;
    logic                  left_up;
    logic                  right_up;
  } frame_cls_t;

endpackage

[sv/hsg_fifo.sv]
// small two-sided queue of classified frames
module hsg_fifo #(
  parameter int W     = 16,
  parameter int DEPTH = 2
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_valid_i,
  output logic         wr_ready_o,
  input  logic [W-1:0] wr_data_i,
  output logic         rd_valid_o,
  input  logic         rd_ready_i,
  output logic [W-1:0] rd_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             wr_en, rd_en;

  assign wr_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign wr_en      = wr_valid_i && wr_ready_o;
  assign rd_en      = rd_valid_o && rd_ready_i;

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[sv/hsg_front.sv]
// front end: change check, deltas, speed threshold and speed classes
module hsg_front #(
  parameter int POS_BITS  = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [TIME_BITS-1:0]           timestamp_i,
  input  logic signed [POS_BITS-1:0]     left_x_i,
  input  logic signed [POS_BITS-1:0]     left_y_i,
  input  logic signed [POS_BITS-1:0]     left_z_i,
  input  logic signed [POS_BITS-1:0]     right_x_i,
  input  logic signed [POS_BITS-1:0]     right_y_i,
  input  logic signed [POS_BITS-1:0]     right_z_i,
  input  logic signed [POS_BITS-1:0]     head_y_i,
  input  logic [hsg_pkg::CFG_W-1:0]      min_speed_i,
  output logic                           q_valid_o,
  input  logic                           q_ready_i,
  output hsg_pkg::frame_cls_t            q_cls_o,
  output logic [TIME_BITS-1:0]           q_ts_o
);

  localparam int DT_LO  = (TIME_BITS > hsg_pkg::DT_CLAMP_BITS) ?
                          hsg_pkg::DT_CLAMP_BITS : TIME_BITS;
  localparam int PROD_W = hsg_pkg::CFG_W + DT_LO;
  localparam int D_W    = POS_BITS + 1;
  localparam int SC_W   = D_W + 8;
  localparam int CMP_W  = (SC_W > PROD_W) ? SC_W : PROD_W;
  localparam int NA     = hsg_pkg::NUM_AXES;

  // last stored frame
  logic signed [POS_BITS-1:0] p_lx_q, p_ly_q, p_lz_q, p_rx_q, p_ry_q, p_rz_q;
  logic [TIME_BITS-1:0]       p_time_q;

  // classification stage
  logic                       s1_vld_q;
  logic                       changed_q, dt_nz_q, big_q, lup_q, rup_q;
  logic signed [D_W-1:0]      d_q [NA];
  logic [PROD_W-1:0]          prod_q;
  logic [TIME_BITS-1:0]       ts_q;

  logic                       accept, push, same;
  logic [TIME_BITS-1:0]       dt;
  logic signed [POS_BITS-1:0] cur [NA];
  logic signed [POS_BITS-1:0] prv [NA];
  logic [D_W-1:0]             mag;
  logic [CMP_W-1:0]           sc, pr;

  assign accept     = in_valid_i && in_ready_o;
  assign push       = s1_vld_q && q_ready_i;
  assign in_ready_o = !s1_vld_q || q_ready_i;
  assign q_valid_o  = s1_vld_q;
  assign q_ts_o     = ts_q;

  assign same = (left_x_i == p_lx_q) && (left_y_i == p_ly_q) && (left_z_i == p_lz_q) &&
                (right_x_i == p_rx_q) && (right_y_i == p_ry_q) && (right_z_i == p_rz_q);
  assign dt   = timestamp_i - p_time_q;

  assign cur[0] = left_x_i;
  assign cur[1] = left_y_i;
  assign cur[2] = right_x_i;
  assign cur[3] = right_y_i;
  assign prv[0] = p_lx_q;
  assign prv[1] = p_ly_q;
  assign prv[2] = p_rx_q;
  assign prv[3] = p_ry_q;

  // stored frame updates on every changed transaction
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_lx_q   <= '0;
      p_ly_q   <= '0;
      p_lz_q   <= '0;
      p_rx_q   <= '0;
      p_ry_q   <= '0;
      p_rz_q   <= '0;
      p_time_q <= '0;
    end else if (accept && !same) begin
      p_lx_q   <= left_x_i;
      p_ly_q   <= left_y_i;
      p_lz_q   <= left_z_i;
      p_rx_q   <= right_x_i;
      p_ry_q   <= right_y_i;
      p_rz_q   <= right_z_i;
      p_time_q <= timestamp_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (accept) begin
      s1_vld_q <= 1'b1;
    end else if (push) begin
      s1_vld_q <= 1'b0;
    end
  end

  // deltas and threshold product, min_speed * dt saturates for huge steps
  always_ff @(posedge clk_i) begin
    if (accept) begin
      changed_q <= !same;
      dt_nz_q   <= (dt != '0);
      big_q     <= ((dt >> DT_LO) != '0) && (min_speed_i != '0);
      prod_q    <= PROD_W'(min_speed_i) * PROD_W'(dt[DT_LO-1:0]);
      lup_q     <= left_y_i > head_y_i;
      rup_q     <= right_y_i > head_y_i;
      ts_q      <= timestamp_i;
      for (int i = 0; i < NA; i++) begin
        d_q[i] <= D_W'(cur[i]) - D_W'(prv[i]);
      end
    end
  end

  // speed classes: delta*256 against the threshold product
  always_comb begin
    mag = '0;
    sc  = '0;
    pr  = CMP_W'(prod_q);
    q_cls_o.changed  = changed_q;
    q_cls_o.dt_nz    = dt_nz_q;
    q_cls_o.left_up  = lup_q;
    q_cls_o.right_up = rup_q;
    for (int i = 0; i < NA; i++) begin
      mag = d_q[i][D_W-1] ? D_W'(-d_q[i]) : D_W'(d_q[i]);
      sc  = CMP_W'({mag, 8'b0});
      q_cls_o.cls[i] = hsg_pkg::CLS_NONE;
      if (!big_q) begin
        if (!d_q[i][D_W-1]) begin
          if (sc >= pr) begin
            q_cls_o.cls[i] = hsg_pkg::CLS_POS;
          end
        end else if (sc > pr) begin
          q_cls_o.cls[i] = hsg_pkg::CLS_NEG;
        end
      end
    end
  end

endmodule

[sv/hsg_back.sv]
// back end: axis tracking, swipe completion, above-head events, result register
module hsg_back #(
  parameter int TIME_BITS = 32
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      q_valid_i,
  output logic                      q_ready_o,
  input  hsg_pkg::frame_cls_t       q_cls_i,
  input  logic [TIME_BITS-1:0]      q_ts_i,
  input  logic [hsg_pkg::CFG_W-1:0] horizontal_gap_i,
  input  logic [hsg_pkg::CFG_W-1:0] vertical_gap_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic                      swipe_left_o,
  output logic                      swipe_right_o,
  output logic                      swipe_up_o,
  output logic                      swipe_down_o,
  output logic                      toggle_event_o,
  output logic                      snapshot_event_o
);

  localparam int NA = hsg_pkg::NUM_AXES;

  logic [NA-1:0]              trk_q, trk_d;
  hsg_pkg::dir_e [NA-1:0]     dir_q, dir_d;
  logic [TIME_BITS-1:0]       lgt_q, lgt_d;
  logic [1:0]                 above_q, above_d;
  logic                       out_vld_q;
  logic                       left_q, right_q, up_q, down_q, tog_q, snap_q;

  logic                       pop, lgt_hit, vert, abv;
  logic                       ev_left, ev_right, ev_up, ev_down, ev_tog, ev_snap;
  logic [TIME_BITS-1:0]       diff, since;
  logic [hsg_pkg::CFG_W-1:0]  gap;

  assign pop       = q_valid_i && (!out_vld_q || out_ready_i);
  assign q_ready_o = !out_vld_q || out_ready_i;
  assign diff      = q_ts_i - lgt_q;

  // axis rules in order, then above-head rules
  always_comb begin
    trk_d    = trk_q;
    dir_d    = dir_q;
    above_d  = above_q;
    lgt_hit  = 1'b0;
    vert     = 1'b0;
    abv      = 1'b0;
    since    = '0;
    gap      = '0;
    ev_left  = 1'b0;
    ev_right = 1'b0;
    ev_up    = 1'b0;
    ev_down  = 1'b0;
    ev_tog   = 1'b0;
    ev_snap  = 1'b0;
    if (q_cls_i.changed) begin
      if (q_cls_i.dt_nz) begin
        for (int i = 0; i < NA; i++) begin
          vert = (i == 1) || (i == 3);
          abv  = ((i == 1) && q_cls_i.left_up) || ((i == 3) && q_cls_i.right_up);
          gap  = vert ? vertical_gap_i : horizontal_gap_i;
          if (q_cls_i.cls[i] != hsg_pkg::CLS_NONE) begin
            if (trk_d == '0) begin
              if (abv) begin
                lgt_hit = 1'b1;
              end
              since = lgt_hit ? '0 : diff;
              if (since >= TIME_BITS'(gap)) begin
                trk_d[i] = 1'b1;
                dir_d[i] = (q_cls_i.cls[i] == hsg_pkg::CLS_POS) ?
                           hsg_pkg::DIR_POS : hsg_pkg::DIR_NEG;
              end
            end
          end else if (trk_d == (NA'(1) << i)) begin
            if (!abv) begin
              if (dir_d[i] == hsg_pkg::DIR_POS) begin
                if (vert) ev_up = 1'b1;
                else      ev_right = 1'b1;
              end else begin
                if (vert) ev_down = 1'b1;
                else      ev_left = 1'b1;
              end
            end
            lgt_hit  = 1'b1;
            trk_d    = '0;
            dir_d[i] = hsg_pkg::DIR_NONE;
          end
        end
      end
      // rising edges of hand above head
      ev_tog     = q_cls_i.right_up && !above_q[1];
      ev_snap    = q_cls_i.left_up && !above_q[0];
      above_d[1] = q_cls_i.right_up;
      above_d[0] = q_cls_i.left_up;
    end
  end

  assign lgt_d = lgt_hit ? q_ts_i : lgt_q;

  // tracker state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trk_q   <= '0;
      dir_q   <= {NA{hsg_pkg::DIR_NONE}};
      lgt_q   <= '0;
      above_q <= '0;
    end else if (pop) begin
      trk_q   <= trk_d;
      dir_q   <= dir_d;
      lgt_q   <= lgt_d;
      above_q <= above_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (pop) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      left_q  <= ev_left;
      right_q <= ev_right;
      up_q    <= ev_up;
      down_q  <= ev_down;
      tog_q   <= ev_tog;
      snap_q  <= ev_snap;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign swipe_left_o     = left_q;
  assign swipe_right_o    = right_q;
  assign swipe_up_o       = up_q;
  assign swipe_down_o     = down_q;
  assign toggle_event_o   = tog_q;
  assign snapshot_event_o = snap_q;

`ifndef ASSERT_OFF
  // only one axis tracks at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot0(trk_q))
    else $error("more than one axis tracking");

  // an axis has a direction exactly while it tracks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((dir_q[0] != hsg_pkg::DIR_NONE) == trk_q[0]) &&
    ((dir_q[1] != hsg_pkg::DIR_NONE) == trk_q[1]) &&
    ((dir_q[2] != hsg_pkg::DIR_NONE) == trk_q[2]) &&
    ((dir_q[3] != hsg_pkg::DIR_NONE) == trk_q[3]))
    else $error("axis direction out of step with tracking");

  // at most one swipe completes per frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> $onehot0({left_q, right_q, up_q, down_q}))
    else $error("several swipes in one result");
`endif

endmodule

[sv/hand_swipe_gesture_detector_core.sv]
// Hand swipe gesture detector top level. Takes one skeleton frame per
// transaction and returns one result of six event flags per frame. Sustained
// rate is one frame per clock while out_ready_i does not hold off results; a
// frame passes through the classifier stage, then the two-entry queue, into the
// result register. The classifier stage holds the one min_speed * dt multiplier
// (step clamped to 40 bits) and the tracker resolves all four axis rules of a
// frame combinationally, ahead of the result register. The queue lets the
// classifier keep taking frames while a result waits. Configuration writes take
// effect at once and should be made while no frame is in flight.
module hand_swipe_gesture_detector_core #(
  parameter int POS_BITS  = 16,
  parameter int TIME_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [hsg_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hsg_pkg::CFG_W-1:0]     cfg_wdata_i,
  // frame input
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [TIME_BITS-1:0]          timestamp_i,
  input  logic signed [POS_BITS-1:0]    left_x_i,
  input  logic signed [POS_BITS-1:0]    left_y_i,
  input  logic signed [POS_BITS-1:0]    left_z_i,
  input  logic signed [POS_BITS-1:0]    right_x_i,
  input  logic signed [POS_BITS-1:0]    right_y_i,
  input  logic signed [POS_BITS-1:0]    right_z_i,
  input  logic signed [POS_BITS-1:0]    head_y_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          swipe_left_o,
  output logic                          swipe_right_o,
  output logic                          swipe_up_o,
  output logic                          swipe_down_o,
  output logic                          toggle_event_o,
  output logic                          snapshot_event_o
);

  localparam int QW = $bits(hsg_pkg::frame_cls_t) + TIME_BITS;

  logic [hsg_pkg::CFG_W-1:0] min_speed_q, h_gap_q, v_gap_q;

  hsg_pkg::frame_cls_t  f_cls, b_cls;
  logic [TIME_BITS-1:0] f_ts, b_ts;
  logic                 f_valid, f_ready, b_valid, b_ready;
  logic [QW-1:0]        b_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_speed_q <= hsg_pkg::MIN_SPEED_RST;
      h_gap_q     <= hsg_pkg::GAP_RST;
      v_gap_q     <= hsg_pkg::GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        hsg_pkg::REG_MIN_SPEED: min_speed_q <= cfg_wdata_i;
        hsg_pkg::REG_H_GAP:     h_gap_q     <= cfg_wdata_i;
        hsg_pkg::REG_V_GAP:     v_gap_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // classifier
  hsg_front #(
    .POS_BITS  (POS_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .timestamp_i (timestamp_i),
    .left_x_i    (left_x_i),
    .left_y_i    (left_y_i),
    .left_z_i    (left_z_i),
    .right_x_i   (right_x_i),
    .right_y_i   (right_y_i),
    .right_z_i   (right_z_i),
    .head_y_i    (head_y_i),
    .min_speed_i (min_speed_q),
    .q_valid_o   (f_valid),
    .q_ready_i   (f_ready),
    .q_cls_o     (f_cls),
    .q_ts_o      (f_ts)
  );

  // queue between classifier and tracker
  hsg_fifo #(
    .W     (QW),
    .DEPTH (hsg_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (f_valid),
    .wr_ready_o (f_ready),
    .wr_data_i  ({f_cls, f_ts}),
    .rd_valid_o (b_valid),
    .rd_ready_i (b_ready),
    .rd_data_o  (b_data)
  );

  assign b_cls = hsg_pkg::frame_cls_t'(b_data[QW-1:TIME_BITS]);
  assign b_ts  = b_data[TIME_BITS-1:0];

  // tracker and result register
  hsg_back #(
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (b_valid),
    .q_ready_o        (b_ready),
    .q_cls_i          (b_cls),
    .q_ts_i           (b_ts),
    .horizontal_gap_i (h_gap_q),
    .vertical_gap_i   (v_gap_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .swipe_left_o     (swipe_left_o),
    .swipe_right_o    (swipe_right_o),
    .swipe_up_o       (swipe_up_o),
    .swipe_down_o     (swipe_down_o),
    .toggle_event_o   (toggle_event_o),
    .snapshot_event_o (snapshot_event_o)
  );

endmodule

[tb/sv/tb_hand_swipe_gesture_detector_core.sv]
// self-checking testbench for the hand swipe gesture detector core
`timescale 1ns / 1ps

module tb_hand_swipe_gesture_detector_core;

  // coordinate slots inside a frame
  localparam int LX = 0;
  localparam int LY = 1;
  localparam int LZ = 2;
  localparam int RX = 3;
  localparam int RY = 4;
  localparam int RZ = 5;

  // register index that maps to no register
  localparam logic [hsg_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic [15:0] HEAD_HIGH = 16'h7FFF;
  localparam logic [15:0] HEAD_LOW  = 16'h8000;

  typedef struct packed {
    logic [31:0]      ts;
    logic [5:0][15:0] hand;
    logic [15:0]      head;
  } frame_t;

  typedef struct packed {
    logic left;
    logic right;
    logic up;
    logic down;
    logic toggle;
    logic snap;
  } flags_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_we_i;
  logic [hsg_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [hsg_pkg::CFG_W-1:0]     cfg_wdata_i;
  logic                          in_valid_i;
  logic                          in_ready_o;
  logic [31:0]                   timestamp_i;
  logic signed [15:0]            left_x_i, left_y_i, left_z_i;
  logic signed [15:0]            right_x_i, right_y_i, right_z_i;
  logic signed [15:0]            head_y_i;
  logic                          out_valid_o;
  logic                          out_ready_i;
  logic                          swipe_left_o, swipe_right_o, swipe_up_o, swipe_down_o;
  logic                          toggle_event_o, snapshot_event_o;

  hand_swipe_gesture_detector_core i_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .timestamp_i      (timestamp_i),
    .left_x_i         (left_x_i),
    .left_y_i         (left_y_i),
    .left_z_i         (left_z_i),
    .right_x_i        (right_x_i),
    .right_y_i        (right_y_i),
    .right_z_i        (right_z_i),
    .head_y_i         (head_y_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .swipe_left_o     (swipe_left_o),
    .swipe_right_o    (swipe_right_o),
    .swipe_up_o       (swipe_up_o),
    .swipe_down_o     (swipe_down_o),
    .toggle_event_o   (toggle_event_o),
    .snapshot_event_o (snapshot_event_o)
  );

  // predictor state and register mirror
  logic [5:0][15:0]          seen_hand     = '0;
  logic [31:0]               seen_ts       = '0;
  logic [31:0]               gesture_ts    = '0;
  logic [3:0]                tracking      = '0;
  logic [7:0]                direction     = '0;
  logic [1:0]                above_head    = '0;
  logic [hsg_pkg::CFG_W-1:0] cfg_min_speed = hsg_pkg::MIN_SPEED_RST;
  logic [hsg_pkg::CFG_W-1:0] cfg_h_gap     = hsg_pkg::GAP_RST;
  logic [hsg_pkg::CFG_W-1:0] cfg_v_gap     = hsg_pkg::GAP_RST;

  flags_t frame_flags [$];
  frame_t cur = '0;

  int  errors          = 0;
  int  frames_sent     = 0;
  int  results_checked = 0;
  int  swipes_seen     = 0;
  int  head_events     = 0;
  int  reg_writes      = 0;
  int  hold_cycles     = 0;
  bit  tx_steady       = 1'b0;
  bit  rx_steady       = 1'b0;

  // clock
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  function automatic int axis_coord(input int axis);
    return (axis < 2) ? axis : axis + 1;
  endfunction

  // speed class without a divide: delta*256 against min_speed*dt
  function automatic hsg_pkg::cls_e classify_speed(input logic signed [15:0] now_pos,
                                                   input logic signed [15:0] old_pos,
                                                   input logic [31:0] dt);
    longint          d;
    longint unsigned scaled;
    longint unsigned prod;
    d      = longint'(now_pos) - longint'(old_pos);
    scaled = ((d < 0) ? -d : d) << 8;
    prod   = 64'(cfg_min_speed) * 64'(dt);
    if (d >= 0) return (scaled >= prod) ? hsg_pkg::CLS_POS : hsg_pkg::CLS_NONE;
    return (scaled > prod) ? hsg_pkg::CLS_NEG : hsg_pkg::CLS_NONE;
  endfunction

  // start and completion rules of one axis
  function automatic void run_axis(input int axis, input hsg_pkg::cls_e cls,
                                   input logic [31:0] t,
                                   input logic [15:0] gap, input bit vertical,
                                   input bit up, output bit pos_ev, output bit neg_ev);
    logic [3:0] mask;
    int         sh;
    pos_ev = 1'b0;
    neg_ev = 1'b0;
    mask   = 4'b1 << axis;
    sh     = axis * 2;
    if (cls != hsg_pkg::CLS_NONE) begin
      if (tracking == '0) begin
        if (vertical && up) gesture_ts = t;
        if ((t - gesture_ts) >= gap) begin
          tracking           = tracking | mask;
          direction[sh +: 2] = (cls == hsg_pkg::CLS_POS) ? hsg_pkg::DIR_POS : hsg_pkg::DIR_NEG;
        end
      end
    end else if (tracking == mask) begin
      if (!(vertical && up)) begin
        if (direction[sh +: 2] == hsg_pkg::DIR_POS) pos_ev = 1'b1;
        else neg_ev = 1'b1;
      end
      gesture_ts         = t;
      tracking           = '0;
      direction[sh +: 2] = hsg_pkg::DIR_NONE;
    end
  endfunction

  // event flags caused by one frame, advancing the predictor state
  function automatic flags_t predict_flags(input frame_t f);
    flags_t        fl;
    logic [31:0]   dt;
    bit            lu, ru, pe, ne;
    hsg_pkg::cls_e cls [hsg_pkg::NUM_AXES];
    int            a;
    fl = '0;
    if (f.hand != seen_hand) begin
      dt = f.ts - seen_ts;
      lu = $signed(f.hand[LY]) > $signed(f.head);
      ru = $signed(f.hand[RY]) > $signed(f.head);
      for (a = 0; a < hsg_pkg::NUM_AXES; a++)
        cls[a] = classify_speed(f.hand[axis_coord(a)], seen_hand[axis_coord(a)], dt);
      seen_hand = f.hand;
      seen_ts   = f.ts;
      if (dt != 0) begin
        for (a = 0; a < hsg_pkg::NUM_AXES; a++) begin
          if (a % 2 == 1) begin
            run_axis(a, cls[a], f.ts, cfg_v_gap, 1'b1, (a == 1) ? lu : ru, pe, ne);
            fl.up   = fl.up | pe;
            fl.down = fl.down | ne;
          end else begin
            run_axis(a, cls[a], f.ts, cfg_h_gap, 1'b0, 1'b0, pe, ne);
            fl.right = fl.right | pe;
            fl.left  = fl.left | ne;
          end
        end
      end
      // above-head rising edges
      if (ru) begin
        if (!above_head[1]) begin
          above_head[1] = 1'b1;
          fl.toggle     = 1'b1;
        end
      end else above_head[1] = 1'b0;
      if (lu) begin
        if (!above_head[0]) begin
          above_head[0] = 1'b1;
          fl.snap       = 1'b1;
        end
      end else above_head[0] = 1'b0;
    end
    return fl;
  endfunction

  // smallest step that counts as fast, plus some margin
  function automatic int fast_step(input int unsigned dt);
    return int'((longint'(cfg_min_speed) * longint'(dt)) / 256) + 1 + $urandom_range(0, 40);
  endfunction

  // move a coordinate, turning back near the range limits
  function automatic logic [15:0] shift_pos(input logic [15:0] p, input int m, input bit neg);
    int base;
    int v;
    base = int'($signed(p));
    v    = neg ? base - m : base + m;
    if (v > 32767) v = base - m;
    if (v < -32768) v = base + m;
    return 16'(v);
  endfunction

  function automatic logic [hsg_pkg::CFG_W-1:0] pick_reg_value(
      input logic [hsg_pkg::CFG_W-1:0] dflt);
    logic [hsg_pkg::CFG_W-1:0] v;
    case ($urandom_range(0, 5))
      0:       v = '0;
      1:       v = '1;
      2:       v = dflt;
      3:       v = hsg_pkg::CFG_W'($urandom);
      default: v = hsg_pkg::CFG_W'($urandom_range(1, 2 * int'(dflt)));
    endcase
    return v;
  endfunction

  function automatic logic [15:0] pick_head();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return HEAD_HIGH;
    if (r < 8) return HEAD_LOW;
    return 16'($urandom);
  endfunction

  // send one frame transaction and record its expected flags
  task automatic send_frame(input frame_t f);
    @(negedge clk_i);
    if (!tx_steady && $urandom_range(0, 99) < 32) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 2)) @(negedge clk_i);
    end
    in_valid_i  = 1'b1;
    timestamp_i = f.ts;
    left_x_i    = f.hand[LX];
    left_y_i    = f.hand[LY];
    left_z_i    = f.hand[LZ];
    right_x_i   = f.hand[RX];
    right_y_i   = f.hand[RY];
    right_z_i   = f.hand[RZ];
    head_y_i    = f.head;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    frame_flags.push_back(predict_flags(f));
    cur = f;
    frames_sent++;
  endtask

  // sender pauses until every pending result is back
  task automatic wait_drain();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (frame_flags.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [hsg_pkg::CFG_IDX_W-1:0] idx,
                           input logic [hsg_pkg::CFG_W-1:0] val);
    wait_drain();
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      hsg_pkg::REG_MIN_SPEED: cfg_min_speed = val;
      hsg_pkg::REG_H_GAP:     cfg_h_gap     = val;
      hsg_pkg::REG_V_GAP:     cfg_v_gap     = val;
      default:                ;
    endcase
    reg_writes++;
  endtask

  // optional rest frame past the gap, fast frames on one axis, then dead-band frames
  task automatic gesture_sequence(input int axis, input bit neg, input logic [15:0] head,
                                  input int steps, input bit mixed, input bit rest);
    frame_t      f;
    int          coord, other, i, gmax;
    int unsigned dt;
    coord = axis_coord(axis);
    gmax  = (cfg_h_gap > cfg_v_gap) ? int'(cfg_h_gap) : int'(cfg_v_gap);
    if (rest) begin
      f         = cur;
      f.ts      = cur.ts + 32'(gmax) + 32'($urandom_range(1, 100));
      f.head    = head;
      f.hand[LZ] = cur.hand[LZ] + 16'($urandom_range(1, 100));
      send_frame(f);
    end
    for (i = 0; i < steps; i++) begin
      f           = cur;
      dt          = $urandom_range(1, 20);
      f.ts        = cur.ts + dt;
      f.head      = head;
      f.hand[coord] = shift_pos(cur.hand[coord], fast_step(dt), neg);
      if (mixed) begin
        other         = axis_coord($urandom_range(0, 3));
        f.hand[other] = shift_pos(cur.hand[other], $urandom_range(0, fast_step(dt)),
                                  $urandom_range(0, 1));
      end
      send_frame(f);
    end
    repeat ($urandom_range(1, 2)) begin
      f      = cur;
      dt     = $urandom_range(1, 20);
      f.ts   = cur.ts + dt;
      f.head = head;
      if ($urandom_range(0, 1) == 1 && longint'(cfg_min_speed) * dt >= 512)
        f.hand[coord] = shift_pos(cur.hand[coord],
          $urandom_range(0, int'((longint'(cfg_min_speed) * dt) / 256) - 1), neg);
      else if ($urandom_range(0, 1) == 1)
        f.hand[LZ] = cur.hand[LZ] + 16'($urandom_range(1, 100));
      else
        f.hand[RZ] = cur.hand[RZ] - 16'($urandom_range(1, 100));
      send_frame(f);
    end
  endtask

  // random frames, still hands, zero time steps and jitter
  task automatic noise_frame();
    frame_t f;
    int     k;
    f = cur;
    case ($urandom_range(0, 3))
      0: begin
        f.ts = $urandom;
        for (k = 0; k < 6; k++) f.hand[k] = 16'($urandom);
        f.head = 16'($urandom);
      end
      1: begin
        f.ts   = cur.ts + 32'($urandom_range(0, 50));
        f.head = 16'($urandom);
      end
      2: begin
        k         = $urandom_range(0, 5);
        f.hand[k] = 16'($urandom);
        f.head    = pick_head();
      end
      default: begin
        f.ts = cur.ts + 32'($urandom_range(1, 40));
        for (k = 0; k < 6; k++)
          f.hand[k] = cur.hand[k] + 16'($urandom_range(0, 400)) - 16'd200;
      end
    endcase
    send_frame(f);
  endtask

  task automatic test_extreme_frames();
    frame_t f;
    // matches the reset positions, so nothing may fire
    f      = '0;
    f.ts   = 32'd100;
    f.head = 16'h1234;
    send_frame(f);
    f.ts   = 32'hFFFF_FFFF;
    f.hand = {6{16'h7FFF}};
    f.head = HEAD_LOW;
    send_frame(f);
    // time stamp wraps to zero
    f.ts   = 32'h0;
    f.hand = {6{16'h8000}};
    f.head = HEAD_HIGH;
    send_frame(f);
    // hands move with no time step
    f.hand[LX] = 16'h0000;
    f.hand[RY] = 16'h0100;
    send_frame(f);
  endtask

  task automatic test_each_swipe();
    gesture_sequence(0, 1'b1, HEAD_HIGH, 1, 1'b0, 1'b1);
    gesture_sequence(2, 1'b0, HEAD_HIGH, 1, 1'b0, 1'b1);
    gesture_sequence(1, 1'b0, HEAD_HIGH, 1, 1'b0, 1'b1);
    gesture_sequence(3, 1'b1, HEAD_HIGH, 1, 1'b0, 1'b1);
  endtask

  task automatic test_above_head();
    frame_t f;
    // both hands rise above the head
    f          = cur;
    f.ts       = cur.ts + 32'd5;
    f.head     = HEAD_LOW;
    f.hand[LY] = 16'h0100;
    f.hand[RY] = 16'h0200;
    send_frame(f);
    // vertical swipe with the hand up: tracked but silent
    write_reg(hsg_pkg::REG_V_GAP, '0);
    gesture_sequence(1, 1'b0, HEAD_LOW, 1, 1'b0, 1'b0);
    // hands drop, then rise again
    f            = cur;
    f.ts         = cur.ts + 32'd3;
    f.head       = HEAD_HIGH;
    f.hand[LZ]   = cur.hand[LZ] + 16'd7;
    send_frame(f);
    f.ts       = f.ts + 32'd3;
    f.head     = HEAD_LOW;
    f.hand[RZ] = cur.hand[RZ] + 16'd9;
    send_frame(f);
    write_reg(hsg_pkg::REG_V_GAP, hsg_pkg::GAP_RST);
  endtask

  task automatic test_register_extremes();
    // every axis fast
    write_reg(hsg_pkg::REG_MIN_SPEED, '0);
    gesture_sequence(0, 1'b0, HEAD_HIGH, 1, 1'b0, 1'b0);
    write_reg(hsg_pkg::REG_MIN_SPEED, '1);
    gesture_sequence(2, 1'b1, HEAD_HIGH, 1, 1'b0, 1'b1);
    write_reg(hsg_pkg::REG_H_GAP, '0);
    write_reg(hsg_pkg::REG_V_GAP, '1);
    gesture_sequence(3, 1'b0, HEAD_HIGH, 1, 1'b0, 1'b0);
    gesture_sequence(0, 1'b0, HEAD_HIGH, 1, 1'b0, 1'b0);
    write_reg(hsg_pkg::REG_H_GAP, '1);
    write_reg(REG_UNUSED, '1);
    write_reg(hsg_pkg::REG_MIN_SPEED, hsg_pkg::MIN_SPEED_RST);
    write_reg(hsg_pkg::REG_H_GAP, hsg_pkg::GAP_RST);
    write_reg(hsg_pkg::REG_V_GAP, hsg_pkg::GAP_RST);
  endtask

  // receiver holds off while the sender keeps offering frames
  task automatic test_backpressure();
    tx_steady   = 1'b1;
    hold_cycles = 80;
    repeat (24) noise_frame();
    wait_drain();
    tx_steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    int phase;
    int start;
    for (phase = 0; phase < 7; phase++) begin
      write_reg(hsg_pkg::REG_MIN_SPEED, pick_reg_value(hsg_pkg::MIN_SPEED_RST));
      write_reg(hsg_pkg::REG_H_GAP, pick_reg_value(hsg_pkg::GAP_RST));
      write_reg(hsg_pkg::REG_V_GAP, pick_reg_value(hsg_pkg::GAP_RST));
      tx_steady = (phase == 3);
      rx_steady = (phase == 3);
      start     = frames_sent;
      while (frames_sent - start < 195) begin
        if ($urandom_range(0, 3) != 0)
          gesture_sequence($urandom_range(0, 3), $urandom_range(0, 1), pick_head(),
                           $urandom_range(1, 3), $urandom_range(0, 7) == 0,
                           $urandom_range(0, 4) != 0);
        else
          noise_frame();
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic check_bit(input string name, input logic want, input logic got);
    if (got !== want) begin
      $error("%s: expected %0b, actual %0b", name, want, got);
      errors++;
    end
  endtask

  // result checker and receiver ready
  initial begin
    flags_t want;
    out_ready_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        if (frame_flags.size() == 0) begin
          $error("result transaction with no frame pending");
          errors++;
        end else begin
          want = frame_flags.pop_front();
          check_bit("swipe_left", want.left, swipe_left_o);
          check_bit("swipe_right", want.right, swipe_right_o);
          check_bit("swipe_up", want.up, swipe_up_o);
          check_bit("swipe_down", want.down, swipe_down_o);
          check_bit("toggle_event", want.toggle, toggle_event_o);
          check_bit("snapshot_event", want.snap, snapshot_event_o);
          results_checked++;
          if (want.left || want.right || want.up || want.down) swipes_seen++;
          if (want.toggle || want.snap) head_events++;
        end
      end
      @(negedge clk_i);
      if (hold_cycles > 0) begin
        out_ready_i = 1'b0;
        hold_cycles--;
      end else if (rx_steady) begin
        out_ready_i = 1'b1;
      end else begin
        out_ready_i = ($urandom_range(0, 99) >= 32);
      end
    end
  end

  // run limit
  initial begin
    #10_000_000;
    $display("tb_hand_swipe_gesture_detector_core: errors");
    $finish;
  end

  // test sequence
  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = hsg_pkg::REG_MIN_SPEED;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    timestamp_i = '0;
    left_x_i    = '0;
    left_y_i    = '0;
    left_z_i    = '0;
    right_x_i   = '0;
    right_y_i   = '0;
    right_z_i   = '0;
    head_y_i    = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_extreme_frames();
    test_each_swipe();
    test_above_head();
    test_register_extremes();
    test_backpressure();
    test_random_traffic();

    wait_drain();
    repeat (8) @(posedge clk_i);
    $display("sent %0d frames, checked %0d results, %0d register writes",
             frames_sent, results_checked, reg_writes);
    $display("results held %0d swipes and %0d above-head events", swipes_seen, head_events);
    if (errors == 0) $display("tb_hand_swipe_gesture_detector_core: clean");
    else $display("tb_hand_swipe_gesture_detector_core: errors");
    $finish;
  end

endmodule

[hand_swipe_gesture_detector_core.f]
sv/hsg_pkg.sv
sv/hsg_fifo.sv
sv/hsg_front.sv
sv/hsg_back.sv
sv/hand_swipe_gesture_detector_core.sv
tb/sv/tb_hand_swipe_gesture_detector_core.sv
